// ===== rtl/sitoa_pkg.sv =====
// sitoa_pkg: shared types, constants and decimal tables for the integer to ascii unit
`default_nettype none

package sitoa_pkg;

    // field widths
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned THR_W   = 34;
    localparam int unsigned DIGIT_W = 4;

    // decimal positions of a 32-bit magnitude, most significant first
    localparam logic [POS_W-1:0] POS_TOP = 4'd9;
    localparam logic [POS_W-1:0] POS_ONES = 4'd0;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    // both queues hold two words
    localparam logic [1:0] QUEUE_FULL = 2'd2;

    // classified number between front and back
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } job_t;

    // one output word
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } out_word_t;

    // digit sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SIGN  = 3'b010,
        ST_DIGIT = 3'b100
    } state_t;

    // power of ten for a decimal position
    function automatic logic [THR_W-1:0] pow10(input logic [POS_W-1:0] pos);
        logic [THR_W-1:0] p;
        begin
            unique case (pos)
                4'd0:    p = 34'd1;
                4'd1:    p = 34'd10;
                4'd2:    p = 34'd100;
                4'd3:    p = 34'd1000;
                4'd4:    p = 34'd10000;
                4'd5:    p = 34'd100000;
                4'd6:    p = 34'd1000000;
                4'd7:    p = 34'd10000000;
                4'd8:    p = 34'd100000000;
                4'd9:    p = 34'd1000000000;
                default: p = '0;
            endcase
            return p;
        end
    endfunction

    // k times the power of ten of a position, k is a constant at each use
    function automatic logic [THR_W-1:0] threshold(input logic [POS_W-1:0] pos,
                                                   input logic [DIGIT_W-1:0] k);
        begin
            return THR_W'(k) * pow10(pos);
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sitoa_front.sv =====
// sitoa_front: accepts numbers, splits sign and magnitude, queues them for the back end
`default_nettype none

module sitoa_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic signed [31:0]   value,
    output logic                      full,
    output logic                      job_valid,
    output sitoa_pkg::job_t           job,
    input  wire logic                 job_take
);

    sitoa_pkg::job_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push_ok;
    logic            take_ok;
    logic [31:0]     raw;
    sitoa_pkg::job_t new_job;

    // classify: sign and unsigned magnitude, the most negative value wraps to 2^31
    always_comb
    begin
        raw         = value;
        new_job.neg = raw[31];
        new_job.mag = raw[31] ? (32'd0 - raw) : raw;
    end

    assign full      = (count_reg == sitoa_pkg::QUEUE_FULL);
    assign job_valid = (count_reg != 2'd0);
    assign job       = slot_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign take_ok   = job_take && job_valid;

    // queue pointers and fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push_ok;
        rd_ptr_next = rd_ptr_reg ^ take_ok;
        count_next  = count_reg + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sitoa_back.sv =====
// sitoa_back: digit sequencer and output queue of ascii words
`default_nettype none

module sitoa_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  sitoa_pkg::job_t       job,
    output logic                  job_take,
    output logic [7:0]            character,
    output logic                  last,
    output logic                  empty,
    input  wire logic             pop
);

    sitoa_pkg::state_t                 state_reg;
    sitoa_pkg::state_t                 state_next;
    logic [sitoa_pkg::VALUE_W-1:0]     rem_reg;
    logic [sitoa_pkg::VALUE_W-1:0]     rem_next;
    logic [sitoa_pkg::POS_W-1:0]       pos_reg;
    logic [sitoa_pkg::POS_W-1:0]       pos_next;
    logic                              started_reg;
    logic                              started_next;

    logic [sitoa_pkg::THR_W-1:0]       thr [10];
    logic [9:1]                        ge;
    logic [sitoa_pkg::DIGIT_W-1:0]     digit;
    logic                              digit_emit;

    sitoa_pkg::out_word_t              oq_reg [2];
    logic                              oq_wr_reg;
    logic                              oq_rd_reg;
    logic [1:0]                        oq_count_reg;
    logic [1:0]                        oq_count_next;
    logic                              oq_room;
    logic                              oq_push;
    logic                              oq_pop;
    sitoa_pkg::out_word_t              oq_word;

    // multiples of the current power of ten and the digit they select
    always_comb
    begin
        for (int k = 0; k < 10; k++)
        begin
            thr[k] = sitoa_pkg::threshold(pos_reg, 4'(k));
        end
        for (int k = 1; k < 10; k++)
        begin
            ge[k] = ({2'b00, rem_reg} >= thr[k]);
        end
        digit = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (ge[k])
            begin
                digit = 4'(k);
            end
        end
    end

    // leading zeros are skipped, the ones position always shows
    assign digit_emit = started_reg || (digit != 4'd0) || (pos_reg == sitoa_pkg::POS_ONES);
    assign oq_room    = (oq_count_reg != sitoa_pkg::QUEUE_FULL);

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        rem_next          = rem_reg;
        pos_next          = pos_reg;
        started_next      = started_reg;
        job_take          = 1'b0;
        oq_push           = 1'b0;
        oq_word.character = sitoa_pkg::CHAR_ZERO + {4'b0000, digit};
        oq_word.last      = (pos_reg == sitoa_pkg::POS_ONES);
        unique case (state_reg)
            sitoa_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take     = 1'b1;
                    rem_next     = job.mag;
                    pos_next     = sitoa_pkg::POS_TOP;
                    started_next = 1'b0;
                    state_next   = job.neg ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_DIGIT;
                end
            end
            sitoa_pkg::ST_SIGN:
            begin
                oq_word.character = sitoa_pkg::CHAR_MINUS;
                oq_word.last      = 1'b0;
                if (oq_room)
                begin
                    oq_push    = 1'b1;
                    state_next = sitoa_pkg::ST_DIGIT;
                end
            end
            sitoa_pkg::ST_DIGIT:
            begin
                if (!digit_emit || oq_room)
                begin
                    oq_push      = digit_emit;
                    started_next = started_reg || digit_emit;
                    rem_next     = rem_reg - thr[digit][sitoa_pkg::VALUE_W-1:0];
                    pos_next     = pos_reg - 4'd1;
                    if (pos_reg == sitoa_pkg::POS_ONES)
                    begin
                        state_next = sitoa_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sitoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sitoa_pkg::ST_IDLE;
            pos_reg     <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
    end

    // output queue control
    assign oq_pop        = pop && !empty;
    assign empty         = (oq_count_reg == 2'd0);
    assign oq_count_next = oq_count_reg + {1'b0, oq_push} - {1'b0, oq_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_reg ^ oq_push;
            oq_rd_reg    <= oq_rd_reg ^ oq_pop;
            oq_count_reg <= oq_count_next;
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= oq_word;
        end
    end

    assign character = oq_reg[oq_rd_reg].character;
    assign last      = oq_reg[oq_rd_reg].last;

endmodule

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii_unit.sv =====
// signed_int_to_decimal_ascii_unit: top level of the signed integer to decimal text converter
`default_nettype none

// Converts each signed 32-bit word pushed in into its decimal text, one ascii
// word per character, most significant first: a leading '-' for negative
// values, no leading zeros, a single '0' for zero, and last set on the final
// character. The digit sequencer loads each item, then takes a sign step when
// negative and one step for each of the ten decimal positions, suppressed
// zeros included; it handles one number at a time and, while the output
// queue has room, finds one digit per cycle by comparing the remainder
// against the nine multiples of the current power of ten. A two-word queue in
// front and a two-word queue at the output let each side stall independently.

module signed_int_to_decimal_ascii_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic signed [31:0] value,
    output logic                    full,
    output logic [7:0]              character,
    output logic                    last,
    output logic                    empty,
    input  wire logic               pop
);

    logic            job_valid;
    logic            job_take;
    sitoa_pkg::job_t job;

    // accept and classify
    sitoa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .full      (full),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // digit generation and output queue
    sitoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .character (character),
        .last      (last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire
